### src/glb_container_chunk_parser_top_assert.svh
// Assertion macros for the container chunk parser.
`ifndef GLB_CONTAINER_CHUNK_PARSER_TOP_ASSERT_SVH
`define GLB_CONTAINER_CHUNK_PARSER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GCCP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GCCP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/gccp_pkg.sv
// ----------------------------------------------------------------------------
// gccp_pkg
// Types and constants shared by the container chunk parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gccp_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int WIDE_BITS   = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;

   localparam logic [31:0] GLB_MAGIC     = 32'h4654_6c67;
   localparam logic [31:0] GLB_VERSION   = 32'h0000_0002;
   localparam logic [31:0] TYPE_JSON     = 32'h4e4f_534a;
   localparam logic [31:0] TYPE_BIN      = 32'h004e_4942;
   localparam int          MIN_FILE_BYTES = 20;
   localparam int          HEADER_BYTES   = 12;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_JSON  = 2'd1;
   localparam logic [1:0] KIND_BIN   = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_TRUNC   = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_FIRST   = 3'd4;
   localparam logic [2:0] ST_DUPJSON = 3'd5;
   localparam logic [2:0] ST_BIN     = 3'd6;

   localparam logic [2:0] IDX_LENGTH_DONE = 3'd3;
   localparam logic [2:0] IDX_TYPE_DONE   = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [1:0] payload_kind;
      logic       unknown_chunk_warning;
      logic       done_res;
      logic [2:0] status;
      logic       has_bin_chunk;
   } rsp_type;

endpackage

`default_nettype wire

### src/gccp_core.sv
// ----------------------------------------------------------------------------
// gccp_core
// Parser state and per-beat next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module gccp_core (
   input  wire             clock,
   input  wire             reset,
   input  wire             accept,
   input  gccp_pkg::req_type req_data,
   output gccp_pkg::rsp_type result
);
   import gccp_pkg::*;

   logic [LENGTH_BITS-1:0] byte_counter_ff, byte_counter_in;
   logic [31:0]            declared_total_ff, declared_total_in;
   logic [31:0]            word_assembler_ff, word_assembler_in;
   logic [1:0]             header_fields_ok_ff, header_fields_ok_in;
   logic                   in_payload_ff, in_payload_in;
   logic [2:0]             chunk_header_index_ff, chunk_header_index_in;
   logic [31:0]            chunk_length_ff, chunk_length_in;
   logic [1:0]             chunk_kind_ff, chunk_kind_in;
   logic [31:0]            payload_remaining_ff, payload_remaining_in;
   logic [1:0]             chunk_ordinal_ff, chunk_ordinal_in;
   logic                   bin_seen_ff, bin_seen_in;
   logic [2:0]             held_error_ff, held_error_in;

   logic                   saturated;
   logic [31:0]            chunk_type;
   logic [WIDE_BITS-1:0]   cursor;
   logic [WIDE_BITS-1:0]   declared_wide;
   logic [WIDE_BITS-1:0]   room;
   logic [2:0]             chunk_err;
   logic [1:0]             new_kind;
   logic [1:0]             kind;
   logic                   warn;
   logic [2:0]             status;
   logic                   has_bin;

   assign saturated     = &byte_counter_ff;
   assign chunk_type    = {req_data.data_byte, word_assembler_ff[31:8]};
   assign cursor        = WIDE_BITS'(byte_counter_ff) + WIDE_BITS'(1);
   assign declared_wide = WIDE_BITS'(declared_total_ff);
   assign room          = (declared_wide > cursor) ? (declared_wide - cursor) : '0;

   always_comb begin
      chunk_err = ST_OK;
      new_kind  = KIND_OTHER;
      if ((chunk_length_ff[1:0] != 2'b00) || (WIDE_BITS'(chunk_length_ff) > room)) begin
         chunk_err = ST_RANGE;
      end else if (chunk_ordinal_ff == 2'd0) begin
         if ((chunk_type != TYPE_JSON) || (chunk_length_ff == 32'd0)) begin
            chunk_err = ST_FIRST;
         end
         new_kind = KIND_JSON;
      end else if (chunk_type == TYPE_JSON) begin
         chunk_err = ST_DUPJSON;
      end else if (chunk_type == TYPE_BIN) begin
         if ((chunk_ordinal_ff != 2'd1) || bin_seen_ff) begin
            chunk_err = ST_BIN;
         end
         new_kind = KIND_BIN;
      end
   end

   always_comb begin
      byte_counter_in       = byte_counter_ff;
      declared_total_in     = declared_total_ff;
      word_assembler_in     = word_assembler_ff;
      header_fields_ok_in   = header_fields_ok_ff;
      in_payload_in         = in_payload_ff;
      chunk_header_index_in = chunk_header_index_ff;
      chunk_length_in       = chunk_length_ff;
      chunk_kind_in         = chunk_kind_ff;
      payload_remaining_in  = payload_remaining_ff;
      chunk_ordinal_in      = chunk_ordinal_ff;
      bin_seen_in           = bin_seen_ff;
      held_error_in         = held_error_ff;
      kind                  = KIND_NONE;
      warn                  = 1'b0;
      status                = ST_OK;
      has_bin               = 1'b0;

      if (!saturated) begin
         word_assembler_in = chunk_type;
         if (byte_counter_ff < LENGTH_BITS'(HEADER_BYTES)) begin
            if ((byte_counter_ff == LENGTH_BITS'(3)) && (word_assembler_in == GLB_MAGIC)) begin
               header_fields_ok_in[0] = 1'b1;
            end
            if ((byte_counter_ff == LENGTH_BITS'(7)) && (word_assembler_in == GLB_VERSION)) begin
               header_fields_ok_in[1] = 1'b1;
            end
            if (byte_counter_ff == LENGTH_BITS'(11)) begin
               declared_total_in = word_assembler_in;
            end
         end else if (held_error_ff == ST_OK) begin
            if (in_payload_ff) begin
               kind                 = chunk_kind_ff;
               payload_remaining_in = payload_remaining_ff - 32'd1;
               if (payload_remaining_ff == 32'd1) begin
                  in_payload_in = 1'b0;
               end
            end else begin
               if (chunk_header_index_ff == IDX_LENGTH_DONE) begin
                  chunk_length_in = word_assembler_in;
               end
               if (chunk_header_index_ff == IDX_TYPE_DONE) begin
                  if (chunk_err != ST_OK) begin
                     held_error_in = chunk_err;
                  end else begin
                     if (new_kind == KIND_BIN) begin
                        bin_seen_in = 1'b1;
                     end
                     warn          = (new_kind == KIND_OTHER);
                     chunk_kind_in = new_kind;
                     if (chunk_ordinal_ff != 2'd2) begin
                        chunk_ordinal_in = chunk_ordinal_ff + 2'd1;
                     end
                     if (chunk_length_ff != 32'd0) begin
                        in_payload_in        = 1'b1;
                        payload_remaining_in = chunk_length_ff;
                     end
                  end
               end
               chunk_header_index_in = chunk_header_index_ff + 3'd1;
            end
         end
         byte_counter_in = byte_counter_ff + LENGTH_BITS'(1);
      end

      if (req_data.last_byte) begin
         if (saturated || (cursor < WIDE_BITS'(MIN_FILE_BYTES)) ||
             (header_fields_ok_in != 2'b11) ||
             (WIDE_BITS'(declared_total_in) != cursor)) begin
            status = ST_HEADER;
         end else if (held_error_in != ST_OK) begin
            status = held_error_in;
         end else if (chunk_header_index_in != 3'd0) begin
            status = ST_TRUNC;
         end else begin
            has_bin = bin_seen_in;
         end
         byte_counter_in       = '0;
         declared_total_in     = '0;
         word_assembler_in     = '0;
         header_fields_ok_in   = '0;
         in_payload_in         = 1'b0;
         chunk_header_index_in = '0;
         chunk_length_in       = '0;
         chunk_kind_in         = KIND_NONE;
         payload_remaining_in  = '0;
         chunk_ordinal_in      = '0;
         bin_seen_in           = 1'b0;
         held_error_in         = ST_OK;
      end
   end

   assign result.payload_byte          = req_data.data_byte;
   assign result.payload_kind          = kind;
   assign result.unknown_chunk_warning = warn;
   assign result.done_res              = req_data.last_byte;
   assign result.status                = status;
   assign result.has_bin_chunk         = has_bin;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_counter_ff       <= '0;
         declared_total_ff     <= '0;
         word_assembler_ff     <= '0;
         header_fields_ok_ff   <= '0;
         in_payload_ff         <= 1'b0;
         chunk_header_index_ff <= '0;
         chunk_length_ff       <= '0;
         chunk_kind_ff         <= KIND_NONE;
         payload_remaining_ff  <= '0;
         chunk_ordinal_ff      <= '0;
         bin_seen_ff           <= 1'b0;
         held_error_ff         <= ST_OK;
      end else if (accept) begin
         byte_counter_ff       <= byte_counter_in;
         declared_total_ff     <= declared_total_in;
         word_assembler_ff     <= word_assembler_in;
         header_fields_ok_ff   <= header_fields_ok_in;
         in_payload_ff         <= in_payload_in;
         chunk_header_index_ff <= chunk_header_index_in;
         chunk_length_ff       <= chunk_length_in;
         chunk_kind_ff         <= chunk_kind_in;
         payload_remaining_ff  <= payload_remaining_in;
         chunk_ordinal_ff      <= chunk_ordinal_in;
         bin_seen_ff           <= bin_seen_in;
         held_error_ff         <= held_error_in;
      end
   end

endmodule

`default_nettype wire

### src/gccp_out_reg.sv
// ----------------------------------------------------------------------------
// gccp_out_reg
// Result register with the valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module gccp_out_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output logic              accept,
   input  gccp_pkg::rsp_type result,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output gccp_pkg::rsp_type rsp_data
);
   import gccp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Hold the beat while the consumer stalls.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/glb_container_chunk_parser_top.sv
// ----------------------------------------------------------------------------
// glb_container_chunk_parser_top
// Streaming checker for a binary glTF container, one byte per beat.
//
//   Channel  Direction  Payload    Handshake
//   req      in         req_type   req_valid / req_stall
//   rsp      out        rsp_type   rsp_valid / rsp_stall
//
// One byte is taken per cycle while req_stall is low; its result is registered and appears in the next cycle.
// Each beat passes through one stage: state update and result register.
// req_stall rises only while a registered result is held by rsp_stall.
// Synchronous reset clears all parser state and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glb_container_chunk_parser_top_assert.svh"

module glb_container_chunk_parser_top (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  gccp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output gccp_pkg::rsp_type rsp_data
);
   import gccp_pkg::*;

   logic    accept;
   rsp_type result;

   gccp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .result   (result)
   );

   gccp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .accept    (accept),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `GCCP_ASSERT(a_status_on_done, (rsp_valid && (rsp_data.status != ST_OK)) |-> rsp_data.done_res, "status set on a beat that is not the last")
   `GCCP_ASSERT(a_bin_needs_ok, (rsp_valid && rsp_data.has_bin_chunk) |-> (rsp_data.done_res && (rsp_data.status == ST_OK)), "BIN flag outside an ok final beat")
   `GCCP_ASSERT(a_warn_on_header, (rsp_valid && rsp_data.unknown_chunk_warning) |-> (rsp_data.payload_kind == KIND_NONE), "warning on a payload beat")
   `GCCP_ASSERT_RST(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for glb_container_chunk_parser_top.
//
// Whole container files are built as byte streams, about half well formed with
// random payloads, plus files with one defect each: bad magic or version,
// wrong declared total, truncated chunk header, misaligned or overrunning
// chunk, bad first chunk, repeated JSON, misplaced or repeated BIN, short
// files and noise. A byte-level parser model predicts every result beat,
// and the monitor compares each accepted beat field by field. Both sides
// idle at random, and the receiver holds off for long stretches now and
// then so that the block backs up into its input.
// ----------------------------------------------------------------------------

module tb;
   import gccp_pkg::*;

   typedef enum int {
      SHAPE_OK, SHAPE_MAGIC, SHAPE_VERSION, SHAPE_TOTAL, SHAPE_SHORT_TOTAL, SHAPE_TRUNC,
      SHAPE_MISALIGN, SHAPE_OVERRUN, SHAPE_FIRST, SHAPE_DUPJSON, SHAPE_BIN, SHAPE_SHORT,
      SHAPE_NOISE
   } file_shape_type;

   localparam int STREAM_BYTES = 1600;
   localparam int LONG_HOLD    = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_beats[$];
   rsp_type byte_results[$];
   int      stream_len = 0;
   int      mismatches = 0;
   int      req_wait = 0;
   int      rsp_wait = 0;
   int      cycle_count = 0;
   int      hold_left = 0;
   logic    hold_off = 1'b0;
   bit      req_calm = 1'b0;
   bit      rsp_calm = 1'b0;

   // parser model state
   logic [LENGTH_BITS-1:0] byte_count;
   logic [31:0]            decl_total;
   logic [31:0]            word_sr;
   logic [31:0]            chunk_len;
   logic [31:0]            body_left;
   logic [1:0]             fields_ok;
   logic [1:0]             body_kind;
   logic [1:0]             chunk_count;
   logic [2:0]             hdr_idx;
   logic [2:0]             first_err;
   logic                   in_body;
   logic                   saw_bin;

   glb_container_chunk_parser_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void clear_parser();
      byte_count  = '0;
      decl_total  = '0;
      word_sr     = '0;
      chunk_len   = '0;
      body_left   = '0;
      fields_ok   = '0;
      body_kind   = KIND_NONE;
      chunk_count = '0;
      hdr_idx     = '0;
      first_err   = ST_OK;
      in_body     = 1'b0;
      saw_bin     = 1'b0;
   endfunction

   // returns the unknown-chunk warning
   function automatic logic close_chunk_header(input logic [31:0] ctype,
                                               input logic [LENGTH_BITS:0] cursor);
      logic [LENGTH_BITS:0] room;
      logic [2:0]           err;
      logic [1:0]           kind;
      room = (decl_total > cursor) ? decl_total - cursor : '0;
      err  = ST_OK;
      kind = KIND_OTHER;
      if (chunk_len[1:0] != 2'b00 || chunk_len > room) begin
         err = ST_RANGE;
      end else if (chunk_count == 2'd0) begin
         if (ctype != TYPE_JSON || chunk_len == 32'd0) err = ST_FIRST;
         kind = KIND_JSON;
      end else if (ctype == TYPE_JSON) begin
         err = ST_DUPJSON;
      end else if (ctype == TYPE_BIN) begin
         if (chunk_count != 2'd1 || saw_bin) err = ST_BIN;
         kind = KIND_BIN;
      end
      if (err != ST_OK) begin
         first_err = err;
         return 1'b0;
      end
      if (kind == KIND_BIN) saw_bin = 1'b1;
      body_kind = kind;
      if (chunk_count < 2'd2) chunk_count = chunk_count + 2'd1;
      if (chunk_len != 32'd0) begin
         in_body   = 1'b1;
         body_left = chunk_len;
      end
      return kind == KIND_OTHER;
   endfunction

   task automatic parse_glb_byte(input req_type beat, output rsp_type res);
      logic                   sat;
      logic [LENGTH_BITS-1:0] pos;
      logic [LENGTH_BITS:0]   count;
      logic [2:0]             idx;
      res = '0;
      res.payload_byte = beat.data_byte;
      res.payload_kind = KIND_NONE;
      res.done_res     = beat.last_byte;
      res.status       = ST_OK;
      sat = (byte_count == {LENGTH_BITS{1'b1}});
      pos = byte_count;
      count = {1'b0, pos} + 1'b1;
      if (!sat) begin
         word_sr = {beat.data_byte, word_sr[31:8]};
         if (pos < HEADER_BYTES) begin
            if (pos == 3 && word_sr == GLB_MAGIC) fields_ok[0] = 1'b1;
            if (pos == 7 && word_sr == GLB_VERSION) fields_ok[1] = 1'b1;
            if (pos == 11) decl_total = word_sr;
         end else if (first_err == ST_OK) begin
            if (in_body) begin
               res.payload_kind = body_kind;
               body_left = body_left - 32'd1;
               if (body_left == 32'd0) in_body = 1'b0;
            end else begin
               idx = hdr_idx;
               if (idx == IDX_LENGTH_DONE) chunk_len = word_sr;
               if (idx == IDX_TYPE_DONE)
                  res.unknown_chunk_warning = close_chunk_header(word_sr, count);
               hdr_idx = idx + 3'd1;
            end
         end
         byte_count = pos + 1'b1;
      end
      if (beat.last_byte) begin
         if (sat || count < MIN_FILE_BYTES || fields_ok != 2'b11 || decl_total != count)
            res.status = ST_HEADER;
         else if (first_err != ST_OK)
            res.status = first_err;
         else if (hdr_idx != 3'd0)
            res.status = ST_TRUNC;
         else
            res.has_bin_chunk = saw_bin;
         clear_parser();
      end
   endtask

   function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] w);
      q.insert(q.size(), w[7:0]);
      q.insert(q.size(), w[15:8]);
      q.insert(q.size(), w[23:16]);
      q.insert(q.size(), w[31:24]);
   endfunction

   function automatic void push_stream(ref logic [7:0] file[$]);
      req_type beat;
      foreach (file[i]) begin
         beat.data_byte = file[i];
         beat.last_byte = (i == file.size() - 1);
         pending_beats.insert(pending_beats.size(), beat);
      end
      stream_len += file.size();
   endfunction

   function automatic logic [31:0] other_type();
      logic [31:0] t;
      t = $urandom_range(0, 1) ? (TYPE_JSON ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
      if (t == TYPE_JSON || t == TYPE_BIN) t = t ^ 32'h0100_0000;
      return t;
   endfunction

   task automatic queue_file(input file_shape_type shape);
      logic [31:0] ctypes[$];
      int          clens[$];
      logic [7:0]  body[$];
      logic [7:0]  file[$];
      logic [31:0] magic;
      logic [31:0] version;
      logic [31:0] total;
      logic [31:0] field;
      int          pick;
      int          at;
      int          keep;
      magic   = GLB_MAGIC;
      version = GLB_VERSION;
      ctypes  = {TYPE_JSON};
      clens   = {4 * $urandom_range(1, 5)};
      if ($urandom_range(0, 1)) begin
         ctypes.insert(ctypes.size(), TYPE_BIN);
         clens.insert(clens.size(), 4 * $urandom_range(0, 5));
      end
      if ($urandom_range(0, 2) == 0) begin
         ctypes.insert(ctypes.size(), other_type());
         clens.insert(clens.size(), 4 * $urandom_range(0, 3));
      end
      case (shape)
         SHAPE_FIRST: begin
            if ($urandom_range(0, 2) == 0) clens[0] = 0;
            else ctypes[0] = $urandom_range(0, 1) ? TYPE_BIN : other_type();
         end
         SHAPE_DUPJSON: begin
            at = $urandom_range(1, ctypes.size());
            ctypes.insert(at, TYPE_JSON);
            clens.insert(at, 4 * $urandom_range(0, 2));
         end
         SHAPE_BIN: begin
            ctypes.insert(1, $urandom_range(0, 1) ? TYPE_BIN : other_type());
            clens.insert(1, 4 * $urandom_range(0, 2));
            ctypes.insert(2, TYPE_BIN);
            clens.insert(2, 4 * $urandom_range(0, 2));
         end
         default: ;
      endcase
      pick = $urandom_range(0, ctypes.size() - 1);
      foreach (ctypes[i]) begin
         field = clens[i];
         if (shape == SHAPE_MISALIGN && i == pick) field = clens[i] + $urandom_range(1, 3);
         if (shape == SHAPE_OVERRUN && i == ctypes.size() - 1) begin
            if ($urandom_range(0, 1)) field = clens[i] + 4 * $urandom_range(1, 4);
            else field = ($urandom | 32'h8000_0000) & 32'hFFFF_FFFC;
         end
         push_word(body, field);
         push_word(body, ctypes[i]);
         repeat (clens[i]) body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
      if (shape == SHAPE_TRUNC)
         repeat ($urandom_range(1, 7)) body.insert(body.size(), 8'($urandom_range(0, 255)));
      total = 12 + body.size();
      case (shape)
         SHAPE_MAGIC:       magic = magic ^ (32'd1 << $urandom_range(0, 31));
         SHAPE_VERSION:     version = version ^ (32'd1 << $urandom_range(0, 31));
         SHAPE_SHORT_TOTAL: total = 12 + $urandom_range(0, 7);
         SHAPE_TOTAL: begin
            case ($urandom_range(0, 2))
               0:       total = total + 4;
               1:       total = total - 4;
               default: total = $urandom;
            endcase
         end
         default: ;
      endcase
      push_word(file, magic);
      push_word(file, version);
      push_word(file, total);
      foreach (body[i]) file.insert(file.size(), body[i]);
      if (shape == SHAPE_SHORT) begin
         keep = $urandom_range(1, 19);
         file = file[0:keep-1];
      end
      if (shape == SHAPE_NOISE) begin
         file.delete();
         repeat ($urandom_range(1, 48)) file.insert(file.size(), 8'($urandom_range(0, 255)));
      end
      push_stream(file);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   initial begin
      logic [7:0] tiny_file[$];
      logic [7:0] lean_file[$];
      int         r;
      clear_parser();
      tiny_file = {8'hFF};
      push_stream(tiny_file);
      push_word(lean_file, GLB_MAGIC);
      push_word(lean_file, GLB_VERSION);
      push_word(lean_file, 32'd24);
      push_word(lean_file, 32'd4);
      push_word(lean_file, TYPE_JSON);
      push_word(lean_file, 32'h00FF_00FF);
      push_stream(lean_file);
      while (stream_len < STREAM_BYTES) begin
         r = $urandom_range(0, 23);
         queue_file(r < 12 ? SHAPE_OK : file_shape_type'(r - 11));
      end
      wait (!reset);
      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (byte_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) begin : drive_bytes
      logic    offer;
      rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            parse_glb_byte(req_data, want);
            byte_results.insert(byte_results.size(), want);
            offer = 1'b0;
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
            req_wait = req_calm ? 0 : $urandom_range(0, 4);
         end
         if (!offer) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_beats.size() != 0) begin
               req_data <= pending_beats.pop_front();
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // hold off the receiver for a long stretch now and then
   always @(posedge clock) begin : hold_results
      if (reset) begin
         cycle_count = 0;
         hold_left   = 0;
         hold_off   <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count % 1000 == 400) hold_left = LONG_HOLD;
         if (hold_left > 0) begin
            hold_left--;
            hold_off <= 1'b1;
         end else begin
            hold_off <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (byte_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("%0t: result beat expected none got %0h", $time, rsp_data);
            end else begin
               want = byte_results.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_data.payload_byte);
               check_field("payload_kind", want.payload_kind, rsp_data.payload_kind);
               check_field("unknown_chunk_warning", want.unknown_chunk_warning,
                           rsp_data.unknown_chunk_warning);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("status", want.status, rsp_data.status);
               check_field("has_bin_chunk", want.has_bin_chunk, rsp_data.has_bin_chunk);
            end
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 4);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= hold_off;
         end
      end
   end

endmodule
